/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ETRC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ETRC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/etrc_pkg.sv */
`timescale 1ns / 1ps

package etrc_pkg;

   localparam int SAMPLE_BITS       = 12;
   localparam int DEF_BUFFER_DEPTH  = 4096;
   localparam int DEF_WINDOW_LENGTH = 128;
   localparam int QUEUE_DEPTH       = 4;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic FUNC_CAPTURE = 1'b1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic       func;
      sample_type sample;
   } req_type;

   typedef struct packed {
      sample_type sample_first;
      sample_type sample_second;
      logic       trigger_found;
      logic       last;
   } rsp_type;

   // classified queue entry
   typedef struct packed {
      logic       capture;
      sample_type sample;
   } entry_type;

   typedef struct packed {
      sample_type level;
      logic       slope;
   } cfg_type;

endpackage

/* design/edge_trigger_ring_capture.sv */
`timescale 1ns / 1ps

// Captures a stream of 12-bit samples into a ring of BUFFER_DEPTH entries and,
// on a capture beat, returns a WINDOW_LENGTH-sample window around the most
// recent crossing of trigger_level (slope 0 falling, 1 rising), two samples per
// result beat, oldest first, with trigger_found set when a crossing was seen
// and last on the final beat. Sample beats are taken one per cycle while the
// four-entry queue ahead of the ring has room. A capture holds the ring's single
// read port, first for a search that starts WINDOW_LENGTH/2 samples back from
// the newest and gives up when its step count reaches BUFFER_DEPTH/4, then for
// two reads per result beat. No clearing pass after reset: a fill count marks
// slots not yet written, which read as 0.
module edge_trigger_ring_capture #(
   parameter int BUFFER_DEPTH  = etrc_pkg::DEF_BUFFER_DEPTH,
   parameter int WINDOW_LENGTH = etrc_pkg::DEF_WINDOW_LENGTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  etrc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output etrc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [etrc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [etrc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [etrc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import etrc_pkg::*;

   localparam logic REG_TRIGGER_LEVEL = 1'b0;
   localparam logic REG_TRIGGER_SLOPE = 1'b1;
   localparam sample_type LEVEL_RESET = SAMPLE_BITS'(2048);

   sample_type  level_ff, level_in;
   logic        slope_ff, slope_in;
   logic        csr_write;
   logic        reg_sel;
   cfg_type     cfg;
   logic        q_valid;
   entry_type   q_data;
   logic        q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      level_in = level_ff;
      slope_in = slope_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_TRIGGER_LEVEL: level_in = csr_pwdata[SAMPLE_BITS-1:0];
            REG_TRIGGER_SLOPE: slope_in = csr_pwdata[0];
            default: begin
               level_in = level_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TRIGGER_LEVEL: csr_prdata = CSR_DATA_W'(level_ff);
         REG_TRIGGER_SLOPE: csr_prdata = CSR_DATA_W'(slope_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
         slope_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         slope_ff <= slope_in;
      end
   end

   assign cfg.level = level_ff;
   assign cfg.slope = slope_ff;

   etrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   etrc_back #(
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/etrc_front.sv */
`timescale 1ns / 1ps

module etrc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  etrc_pkg::req_type  req_data,
   output logic               q_valid,
   output etrc_pkg::entry_type q_data,
   input  logic               q_pop
);
   import etrc_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   entry_type        entry_in;
   logic [QW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QW:0]      count_ff, count_in;
   logic             push;
   logic             pop;

   // classify the beat
   always_comb begin
      entry_in.capture = (req_data.func == FUNC_CAPTURE);
      entry_in.sample  = entry_in.capture ? '0 : req_data.sample;
   end

   assign req_ready = (count_ff != (QW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

/* design/etrc_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module etrc_back #(
   parameter int BUFFER_DEPTH  = etrc_pkg::DEF_BUFFER_DEPTH,
   parameter int WINDOW_LENGTH = etrc_pkg::DEF_WINDOW_LENGTH
) (
   input  logic                clock,
   input  logic                reset,
   input  etrc_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  etrc_pkg::entry_type q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output etrc_pkg::rsp_type   rsp_data
);
   import etrc_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int SW = $clog2(BUFFER_DEPTH / 4) + 1;
   localparam int PW = $clog2(WINDOW_LENGTH / 2);

   localparam logic [AW-1:0] BACKOFF    = AW'(WINDOW_LENGTH / 2);
   localparam logic [AW-1:0] PRE_TRIG   = AW'(WINDOW_LENGTH / 2 - 1);
   localparam logic [AW-1:0] FALL_WIN   = AW'(BUFFER_DEPTH / 2 - WINDOW_LENGTH / 2);
   localparam logic [SW-1:0] STEP_LIMIT = SW'(BUFFER_DEPTH / 4);
   localparam logic [PW-1:0] LAST_PAIR  = PW'(WINDOW_LENGTH / 2 - 1);
   localparam logic [AW:0]   FULL_FILL  = (AW+1)'(BUFFER_DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PRIME  = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_WIN0   = 3'd3;
   localparam logic [2:0] S_WIN1   = 3'd4;
   localparam logic [2:0] S_WIN2   = 3'd5;

   sample_type      ring_ff [BUFFER_DEPTH];
   sample_type      rd_q_ff;
   logic            rd_hit_ff;
   sample_type      rd_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   newest_ff, newest_in;
   logic [AW:0]     fill_ff, fill_in;
   logic [AW-1:0]   cur_ff, cur_in;
   logic [SW-1:0]   step_ff, step_in;
   sample_type      prev_ff, prev_in;
   logic            found_ff, found_in;
   logic [AW-1:0]   win_ff, win_in;
   logic [PW-1:0]   pair_ff, pair_in;
   sample_type      first_ff, first_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            slot_free;
   logic            crossing;

   // unwritten slots read as zero
   assign rd_data   = rd_hit_ff ? rd_q_ff : '0;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign wr_addr   = newest_ff + 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (cfg.slope) begin
         crossing = (prev_ff > cfg.level) && (rd_data <= cfg.level);
      end else begin
         crossing = (prev_ff < cfg.level) && (rd_data >= cfg.level);
      end
   end

   always_comb begin
      state_in     = state_ff;
      newest_in    = newest_ff;
      fill_in      = fill_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      win_in       = win_ff;
      pair_in      = pair_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff - 1'b1;
      wr_en        = 1'b0;
      q_pop        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_data.capture) begin
                  rd_en    = 1'b1;
                  rd_addr  = newest_ff - BACKOFF;
                  cur_in   = newest_ff - BACKOFF;
                  state_in = S_PRIME;
               end else begin
                  wr_en     = 1'b1;
                  newest_in = wr_addr;
                  if (fill_ff != FULL_FILL) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
         end
         S_PRIME: begin
            prev_in  = rd_data;
            rd_en    = 1'b1;
            cur_in   = cur_ff - 1'b1;
            step_in  = SW'(1);
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (step_ff >= STEP_LIMIT) begin
               found_in = 1'b0;
               win_in   = cur_ff + FALL_WIN;
               state_in = S_WIN0;
            end else if (crossing) begin
               found_in = 1'b1;
               win_in   = cur_ff - PRE_TRIG;
               state_in = S_WIN0;
            end else begin
               prev_in = rd_data;
               rd_en   = 1'b1;
               cur_in  = cur_ff - 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         S_WIN0: begin
            rd_en    = 1'b1;
            rd_addr  = win_ff;
            state_in = S_WIN1;
         end
         S_WIN1: begin
            first_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = win_ff + 1'b1;
            state_in = S_WIN2;
         end
         S_WIN2: begin
            if (slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sample_first  = first_ff;
               rsp_data_in.sample_second = rd_data;
               rsp_data_in.trigger_found = found_ff;
               rsp_data_in.last          = (pair_ff == LAST_PAIR);
               win_in                    = win_ff + AW'(2);
               if (pair_ff == LAST_PAIR) begin
                  pair_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  pair_in  = pair_ff + 1'b1;
                  state_in = S_WIN0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         newest_ff    <= '1;
         fill_ff      <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         fill_ff      <= fill_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      step_ff     <= step_in;
      prev_ff     <= prev_in;
      found_ff    <= found_in;
      win_ff      <= win_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= q_data.sample;
      end
      if (rd_en) begin
         rd_q_ff   <= ring_ff[rd_addr];
         rd_hit_ff <= ({1'b0, rd_addr} < fill_ff);
      end
   end

   `ETRC_ASSERT_ALWAYS(a_fill_bound, reset || fill_ff <= FULL_FILL, "fill count past ring depth")
   `ETRC_ASSERT(a_step_bound, state_ff == S_SEARCH |-> step_ff <= STEP_LIMIT, "search overran")
   `ETRC_ASSERT(a_pair_idle, state_ff == S_IDLE |-> pair_ff == '0, "window count left over")
   `ETRC_ASSERT(a_rw_excl, !(wr_en && rd_en), "ring written and read together")

endmodule
